### rtl/postfix_expression_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Same-cycle and next-cycle implication checks, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PFX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types of the postfix expression evaluator: token and result
// transfers, operator codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIV_ZERO  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic               is_number;
        logic signed [31:0] token_value;
        t_opcode            opcode;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        t_status            status;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/pfx_ram.sv
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator on signed Q16.16 values: numbers are pushed,
// operators pop two entries and push the saturated result, the last token
// of an expression delivers the top of stack and a status code.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  tokens    in         i_in_valid/o_in_stall   i_in_data  (t_in_item)
//  results   out        o_out_valid/i_out_stall o_out_data (t_out_item)
//
//  A number or a skipped token is done in S_IDLE, add and subtract in S_READ,
//  multiply in S_MUL, divide in S_READ when it saturates early or divides by
//  zero, else in S_DIV with a radix-2 divider that retires one quotient bit a cycle.
//  The top of stack lives in a register, the rest in a RAM with one read port.
//  Reset is synchronous and clears the state, stack count, error and result valid.
//  A pending result that is stalled holds off the next token only.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [4:0] DIV_LAST_STEP = 5'd31;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    t_status            r_err, n_err;
    logic signed [31:0] r_tos, n_tos;
    logic signed [31:0] r_b, n_b;
    t_opcode            r_op, n_op;
    logic               r_last, n_last;
    logic signed [63:0] r_prod, n_prod;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_dvd, n_dvd;
    logic [31:0]        r_quo, n_quo;
    logic [31:0]        r_mb, n_mb;
    logic               r_neg, n_neg;
    logic [4:0]         r_iter, n_iter;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_xfer;
    logic               fin;
    logic               fin_last;
    logic               wr_en;
    logic               rd_en;
    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      count_m2;
    logic [31:0]        rd_raw;
    logic signed [31:0] op_a;
    logic [32:0]        sum;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic signed [47:0] mul_q;
    logic [32:0]        div_t;
    logic [32:0]        div_d;
    logic               div_ge;

    // Convert an unsigned quotient magnitude to a saturated signed value
    function automatic logic signed [31:0] quo_to_fix(input logic [31:0] q, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            res = (q > 32'h8000_0000) ? Q_MIN : -$signed(q);
        end else begin
            res = q[31] ? Q_MAX : $signed(q);
        end
        return res;
    endfunction

    pfx_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(count_m1[AW-1:0]),
        .i_wr_data(r_tos),
        .i_rd_en  (rd_en),
        .i_rd_addr(count_m2[AW-1:0]),
        .o_rd_data(rd_raw)
    );

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign count_m1 = r_count - CW'(1);
    assign count_m2 = r_count - CW'(2);

    // Shared datapath: operand A comes from the RAM, operand B from the old top
    assign op_a  = $signed(rd_raw);
    assign sum   = (r_op == OP_SUB) ? ({op_a[31], op_a} - {r_b[31], r_b})
                                    : ({op_a[31], op_a} + {r_b[31], r_b});
    assign mag_a = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign mag_b = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign mul_q = r_prod[63:16] + 48'(r_prod[63] && (r_prod[15:0] != 16'd0));
    assign div_t = {r_rem, r_dvd[31]};
    assign div_d = div_t - {1'b0, r_mb};
    assign div_ge = (div_t >= {1'b0, r_mb});

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_tos       = r_tos;
        n_b         = r_b;
        n_op        = r_op;
        n_last      = r_last;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_mb        = r_mb;
        n_neg       = r_neg;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        fin         = 1'b0;
        fin_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    fin_last = i_in_data.last;
                    n_last   = i_in_data.last;
                    if (r_err != ST_OK) begin
                        fin = 1'b1;
                    end else if (i_in_data.is_number) begin
                        fin = 1'b1;
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_err = ST_OVERFLOW;
                        end else begin
                            // spill the old top into the RAM
                            wr_en   = (r_count != '0);
                            n_tos   = i_in_data.token_value;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count < CW'(2)) begin
                        fin   = 1'b1;
                        n_err = ST_UNDERFLOW;
                    end else begin
                        rd_en   = 1'b1;
                        n_b     = r_tos;
                        n_op    = i_in_data.opcode;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_count = count_m1;
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        fin   = 1'b1;
                        n_tos = (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX)
                                                     : $signed(sum[31:0]);
                    end
                    OP_MUL: begin
                        n_prod  = op_a * r_b;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_neg = op_a[31] ^ r_b[31];
                        if (r_b == 32'sd0) begin
                            fin   = 1'b1;
                            n_err = ST_DIV_ZERO;
                        end else if ({16'd0, mag_a[31:16]} >= mag_b) begin
                            // quotient magnitude reaches 2^32: saturate at once
                            fin   = 1'b1;
                            n_tos = (op_a[31] ^ r_b[31]) ? Q_MIN : Q_MAX;
                        end else begin
                            n_rem   = {16'd0, mag_a[31:16]};
                            n_dvd   = {mag_a[15:0], 16'd0};
                            n_mb    = mag_b;
                            n_quo   = '0;
                            n_iter  = '0;
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                fin   = 1'b1;
                n_tos = ((&mul_q[47:31]) || !(|mul_q[47:31])) ? mul_q[31:0]
                        : (mul_q[47] ? Q_MIN : Q_MAX);
            end
            S_DIV: begin
                n_rem  = div_ge ? div_d[31:0] : div_t[31:0];
                n_quo  = {r_quo[30:0], div_ge};
                n_dvd  = {r_dvd[30:0], 1'b0};
                n_iter = r_iter + 5'd1;
                if (r_iter == DIV_LAST_STEP) begin
                    fin   = 1'b1;
                    n_tos = quo_to_fix({r_quo[30:0], div_ge}, r_neg);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
            if (fin_last) begin
                n_out_valid = 1'b1;
                if (n_err != ST_OK) begin
                    n_out.status       = n_err;
                    n_out.result_value = '0;
                end else if (n_count == '0) begin
                    n_out.status       = ST_UNDERFLOW;
                    n_out.result_value = '0;
                end else begin
                    n_out.status       = ST_OK;
                    n_out.result_value = n_tos;
                end
                n_count = '0;
                n_err   = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_tos  <= n_tos;
        r_b    <= n_b;
        r_op   <= n_op;
        r_last <= n_last;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_quo  <= n_quo;
        r_mb   <= n_mb;
        r_neg  <= n_neg;
        r_iter <= n_iter;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

### rtl/pfx_checker.sv
// ----------------------------------------------------------------------------
// pfx_checker
// Port-level checks on the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pfx_checker
    import pfx_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    `PFX_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_out_data), "stalled result changed")

    `PFX_ASSERT_NOW(a_err_zero, o_out_valid && (o_out_data.status != ST_OK),
                    o_out_data.result_value == 32'sd0, "error result is not zero")

    `PFX_ASSERT_NEXT(a_num_last,
                     i_in_valid && !o_in_stall && i_in_data.is_number && i_in_data.last,
                     o_out_valid, "last number token gave no result")

    `PFX_ASSERT_NOW(a_no_overrun, o_out_valid && i_out_stall, o_in_stall,
                    "token taken while result is stalled")

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);

`default_nettype wire
